// ===== design/hht_pkg.sv =====
// Shared types and codes for the hopscotch hash table.
// Depends on nothing; the hash table and the testbench import it.
package hht_pkg;

  // Fixed field widths of the command and result ports.
  localparam int unsigned KeyFieldBits   = 64;
  localparam int unsigned ValueFieldBits = 64;
  localparam int unsigned HomeFieldBits  = 10;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                      opcode;
    logic [KeyFieldBits-1:0]   lookup_key;
    logic [HomeFieldBits-1:0]  home_bucket;
    logic [ValueFieldBits-1:0] new_value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic [ValueFieldBits-1:0] found_value;
  } result_t;

endpackage

// ===== design/hht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hopscotch_hash_table.sv =====
// Hopscotch hash table: find and insert over three RAMs with registered read data.
// A find reduces the home bucket modulo TABLE_SIZE, then checks the slots marked in its hop bitmap;
// an insert also scans for a free slot and displaces entries until it lies within HOP_RANGE of home.
// The block takes one command at a time, accepting a new one only while idle.
// Reset: a clearing pass over all TABLE_SIZE slots zeroes used flags and hop bitmaps, busy high.
// Each result is shown for one cycle with done; the receiver cannot stall it.
module hopscotch_hash_table #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned HOP_RANGE  = 32,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hht_pkg::cmd_t    cmd,
  output logic             done,
  output hht_pkg::result_t result
);
  import hht_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_SIZE);
  localparam int unsigned HW  = $clog2(HOP_RANGE);
  localparam int unsigned KVW = KEY_BITS + VALUE_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_RD_HOME, S_HOME_W, S_LOC, S_LOC_W,
    S_SCAN, S_SCAN_W, S_PLACE, S_PULL_RD, S_PULL_W, S_MV_RD, S_MV_W1, S_MV_W2
  } state_t;

  state_t                  state;
  logic                    op;
  logic [KEY_BITS-1:0]     key;
  logic [VALUE_BITS-1:0]   val;
  logic [HomeFieldBits-1:0] hb;
  logic [AW-1:0]           home;
  logic [HOP_RANGE-1:0]    hop_home;
  logic [HOP_RANGE-1:0]    hop_st;
  logic [HW-1:0]           idx;
  logic [HW-1:0]           dsp;
  logic [HW-1:0]           jr;
  logic [AW:0]             f;
  logic [AW-1:0]           st;
  logic [AW-1:0]           clr;

  // RAM ports
  logic                    kv_we, used_we, hop_we;
  logic [AW-1:0]           kv_waddr, used_waddr, hop_waddr;
  logic [AW-1:0]           kv_raddr, used_raddr, hop_raddr;
  logic [KVW-1:0]          kv_wdata, kv_rd;
  logic                    used_wdata;
  logic [0:0]              used_rd;
  logic [HOP_RANGE-1:0]    hop_wdata, hop_rd;

  // Address arithmetic
  logic [AW:0]             loc_a, start_a, c_a, hop_dist;
  logic                    dist_ok;
  logic [HOP_RANGE-1:0]    cand, low;
  logic [HW-1:0]           j_next;
  logic                    key_hit;

  assign loc_a    = {1'b0, home} + (AW+1)'(idx);
  assign start_a  = f - (AW+1)'(dsp);
  assign c_a      = {1'b0, st} + (AW+1)'(jr);
  assign hop_dist = f - {1'b0, home};
  assign dist_ok  = hop_dist < (AW+1)'(HOP_RANGE);
  assign key_hit  = kv_rd[KVW-1:VALUE_BITS] == key;

  // Pick the earliest displaceable entry below the displacement distance
  always_comb begin
    cand   = hop_rd & ((HOP_RANGE'(1) << dsp) - HOP_RANGE'(1));
    low    = cand & (~cand + HOP_RANGE'(1));
    j_next = '0;
    for (int k = 0; k < HOP_RANGE; k++) begin
      if (low[k]) begin
        j_next = j_next | HW'(k);
      end
    end
  end

  // Steer RAM ports from the sequencer state
  always_comb begin
    kv_we      = 1'b0;
    kv_waddr   = f[AW-1:0];
    kv_wdata   = kv_rd;
    used_we    = 1'b0;
    used_waddr = f[AW-1:0];
    used_wdata = 1'b1;
    hop_we     = 1'b0;
    hop_waddr  = st;
    hop_wdata  = hop_st;
    kv_raddr   = (state == S_LOC) ? loc_a[AW-1:0] : c_a[AW-1:0];
    used_raddr = f[AW-1:0];
    hop_raddr  = (state == S_RD_HOME) ? home : start_a[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr;
        used_wdata = 1'b0;
        hop_we     = 1'b1;
        hop_waddr  = clr;
        hop_wdata  = '0;
      end
      S_PLACE: begin
        if (dist_ok) begin
          kv_we     = 1'b1;
          kv_wdata  = {key, val};
          used_we   = 1'b1;
          hop_we    = 1'b1;
          hop_waddr = home;
          hop_wdata = hop_home | (HOP_RANGE'(1) << hop_dist[HW-1:0]);
        end
      end
      S_MV_W1: begin
        kv_we   = 1'b1;
        used_we = 1'b1;
        hop_we  = 1'b1;
      end
      S_MV_W2: begin
        used_we    = 1'b1;
        used_waddr = c_a[AW-1:0];
        used_wdata = 1'b0;
      end
      default: begin
      end
    endcase
  end

  hht_ram #(.WIDTH(KVW), .DEPTH(TABLE_SIZE)) u_kv_ram (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
    .raddr(kv_raddr), .rdata(kv_rd)
  );

  hht_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_used_ram (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(used_raddr), .rdata(used_rd)
  );

  hht_ram #(.WIDTH(HOP_RANGE), .DEPTH(TABLE_SIZE)) u_hop_ram (
    .clk(clk), .we(hop_we), .waddr(hop_waddr), .wdata(hop_wdata),
    .raddr(hop_raddr), .rdata(hop_rd)
  );

  assign busy = (state != S_IDLE);

  // Sequencer: hold state, advance through the command, register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= cmd.opcode;
            key   <= cmd.lookup_key[KEY_BITS-1:0];
            val   <= cmd.new_value[VALUE_BITS-1:0];
            hb    <= cmd.home_bucket;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (32'(hb) >= TABLE_SIZE) begin
            hb <= hb - HomeFieldBits'(TABLE_SIZE);
          end else begin
            home  <= AW'(hb);
            state <= S_RD_HOME;
          end
        end
        S_RD_HOME: state <= S_HOME_W;
        S_HOME_W: begin
          hop_home <= hop_rd;
          idx      <= '0;
          state    <= S_LOC;
        end
        S_LOC: begin
          if (hop_home[idx] && loc_a < (AW+1)'(TABLE_SIZE)) begin
            state <= S_LOC_W;
          end else if (idx == HW'(HOP_RANGE - 1)) begin
            if (op == OP_FIND) begin
              state  <= S_IDLE;
              done   <= 1'b1;
              result <= '{ST_NOT_FOUND, '0};
            end else begin
              f     <= {1'b0, home};
              state <= S_SCAN;
            end
          end else begin
            idx <= idx + HW'(1);
          end
        end
        S_LOC_W: begin
          if (key_hit) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (op == OP_FIND) begin
              result <= '{ST_OK, ValueFieldBits'(kv_rd[VALUE_BITS-1:0])};
            end else begin
              result <= '{ST_DUPLICATE, '0};
            end
          end else if (idx == HW'(HOP_RANGE - 1)) begin
            if (op == OP_FIND) begin
              state  <= S_IDLE;
              done   <= 1'b1;
              result <= '{ST_NOT_FOUND, '0};
            end else begin
              f     <= {1'b0, home};
              state <= S_SCAN;
            end
          end else begin
            idx   <= idx + HW'(1);
            state <= S_LOC;
          end
        end
        S_SCAN: state <= S_SCAN_W;
        S_SCAN_W: begin
          if (!used_rd[0]) begin
            state <= S_PLACE;
          end else if (f == (AW+1)'(TABLE_SIZE - 1)) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{ST_FULL, '0};
          end else begin
            f     <= f + (AW+1)'(1);
            state <= S_SCAN;
          end
        end
        S_PLACE: begin
          if (dist_ok) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{ST_OK, '0};
          end else begin
            dsp   <= HW'(HOP_RANGE - 1);
            state <= S_PULL_RD;
          end
        end
        S_PULL_RD: state <= S_PULL_W;
        S_PULL_W: begin
          if (cand != '0 && f >= (AW+1)'(dsp)) begin
            st     <= start_a[AW-1:0];
            jr     <= j_next;
            hop_st <= (hop_rd | (HOP_RANGE'(1) << dsp)) & ~(HOP_RANGE'(1) << j_next);
            state  <= S_MV_RD;
          end else if (dsp == HW'(1)) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{ST_FULL, '0};
          end else begin
            dsp   <= dsp - HW'(1);
            state <= S_PULL_RD;
          end
        end
        S_MV_RD: state <= S_MV_W1;
        S_MV_W1: state <= S_MV_W2;
        S_MV_W2: begin
          f     <= c_a;
          state <= S_PLACE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // One result per command: a result cycle is never followed by another
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back result strobes");

  // An accepted command keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // Only a successful find carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> result.found_value == '0)
    else $error("nonzero value on failed command");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the hopscotch hash table: directed rows, then random finds and inserts.
// Depends on hht_pkg and hopscotch_hash_table; a built-in predictor supplies the expected results of untyped rows.
`timescale 1ns / 1ps

module testbench;
  import hht_pkg::*;

  localparam int unsigned Slots     = 1024;
  localparam int unsigned Hops      = 32;
  localparam int          RandItems = 1500;
  localparam int          DirRows   = 16;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;

  // Predictor state of the table
  logic [63:0] tab_key [Slots];
  logic [63:0] tab_val [Slots];
  bit          tab_used [Slots];
  logic [31:0] tab_hop [Slots];

  result_t     expected_results [$];
  logic [63:0] known_keys [$];
  logic [9:0]  known_homes [$];
  int          errors = 0;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic [9:0]  home;
    logic [63:0] val;
    bit          typed;
    status_t     st;
    logic [63:0] value;
  } dir_row_t;

  dir_row_t dir_rows [DirRows];

  hopscotch_hash_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Slot holding key in home's neighborhood, or -1
  function automatic int find_slot(logic [9:0] home, logic [63:0] key);
    for (int i = 0; i < Hops; i++) begin
      if (tab_hop[home][i] && (home + i) < Slots && tab_key[home + i] == key) return home + i;
    end
    return -1;
  endfunction

  // Move the earliest displaceable entry into free slot f; return the vacated slot
  function automatic int pull_entry(int f);
    int base;
    int c;
    for (int d = Hops - 1; d >= 1; d--) begin
      if (f >= d) begin
        base = f - d;
        for (int j = 0; j < d; j++) begin
          if (tab_hop[base][j]) begin
            c = base + j;
            tab_key[f]  = tab_key[c];
            tab_val[f]  = tab_val[c];
            tab_used[f] = 1'b1;
            tab_used[c] = 1'b0;
            tab_hop[base][d] = 1'b1;
            tab_hop[base][j] = 1'b0;
            return c;
          end
        end
      end
    end
    return -1;
  endfunction

  function automatic status_t insert_entry(int home, logic [63:0] key, logic [63:0] val);
    int f;
    f = -1;
    for (int i = home; i < Slots; i++) begin
      if (!tab_used[i]) begin
        f = i;
        break;
      end
    end
    while (f >= 0) begin
      if (f - home < Hops) begin
        tab_key[f]  = key;
        tab_val[f]  = val;
        tab_used[f] = 1'b1;
        tab_hop[home][f - home] = 1'b1;
        return ST_OK;
      end
      f = pull_entry(f);
    end
    return ST_FULL;
  endfunction

  // Expected result of one command; updates the predicted table
  function automatic result_t table_response(cmd_t c);
    result_t r;
    int at;
    r = '0;
    at = find_slot(c.home_bucket, c.lookup_key);
    if (c.opcode == OP_FIND) begin
      if (at >= 0) begin
        r.status = ST_OK;
        r.found_value = tab_val[at];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (at >= 0) begin
      r.status = ST_DUPLICATE;
    end else begin
      r.status = insert_entry(c.home_bucket, c.lookup_key, c.new_value);
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random command: clustered homes so the table fills, displaces and runs full
  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    int   k;
    c.opcode    = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_FIND;
    c.new_value = rand64();
    c.lookup_key = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 40)      c.home_bucket = 10'($urandom_range(960, 1023));
    else if (pick < 70) c.home_bucket = 10'($urandom_range(200, 240));
    else                c.home_bucket = 10'($urandom_range(0, 1023));
    // reuse a known key: hits for finds, duplicates for inserts
    if (known_keys.size() > 0 && $urandom_range(0, 99) < (c.opcode == OP_FIND ? 60 : 15)) begin
      k = $urandom_range(0, known_keys.size() - 1);
      c.lookup_key  = known_keys[k];
      c.home_bucket = known_homes[k];
    end
    return c;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no command outstanding");
      end else begin
        if (result.status !== expected_results[0].status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, expected_results[0].status));
        if (result.found_value !== expected_results[0].found_value)
          report_mismatch($sformatf("found_value %h, expected %h",
                                    result.found_value, expected_results[0].found_value));
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    cmd_t    cur;
    bit      cur_typed;
    result_t cur_exp;
    result_t pred;
    int      idx;
    int      gap;
    int      burst;
    int      total;
    int      wait_cycles;

    dir_rows = '{
      '{OP_FIND,   64'd0, 10'd0, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0},
      '{OP_INSERT, 64'd0, 10'd0, 64'd0, 1'b1, ST_OK, 64'd0},
      '{OP_INSERT, 64'd0, 10'd0, 64'd5, 1'b1, ST_DUPLICATE, 64'd0},
      '{OP_FIND,   64'd0, 10'd0, 64'd7, 1'b1, ST_OK, 64'd0},
      '{OP_INSERT, '1, 10'h3FF, '1, 1'b1, ST_OK, 64'd0},
      '{OP_FIND,   '1, 10'h3FF, 64'd0, 1'b1, ST_OK, '1},
      '{OP_INSERT, 64'd1, 10'h3FF, 64'd9, 1'b1, ST_FULL, 64'd0},
      '{OP_FIND,   64'd1, 10'h3FF, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0},
      '{OP_FIND,   '1, 10'd0, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0},
      '{OP_INSERT, {32{2'b01}}, 10'd512, {32{2'b10}}, 1'b1, ST_OK, 64'd0},
      '{OP_FIND,   {32{2'b01}}, 10'd512, 64'd0, 1'b1, ST_OK, {32{2'b10}}},
      '{OP_INSERT, {32{2'b10}}, 10'd512, {32{2'b01}}, 1'b1, ST_OK, 64'd0},
      '{OP_FIND,   {32{2'b10}}, 10'd512, 64'd0, 1'b1, ST_OK, {32{2'b01}}},
      '{OP_INSERT, 64'd2, 10'd1, 64'h8000_0000_0000_0001, 1'b0, ST_OK, 64'd0},
      '{OP_INSERT, 64'd3, 10'd0, 64'd3, 1'b0, ST_OK, 64'd0},
      '{OP_FIND,   64'd3, 10'd0, 64'd0, 1'b0, ST_OK, 64'd0}
    };
    for (int i = 0; i < Slots; i++) begin
      tab_key[i] = '0;
      tab_val[i] = '0;
      tab_used[i] = 1'b0;
      tab_hop[i] = '0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    total = DirRows + RandItems;
    idx = 0;
    gap = 0;
    burst = $urandom_range(1, 40);
    while (idx < total || start) begin
      @(posedge clk);
      // record the transfer that happens at this edge
      if (start && !busy) begin
        pred = table_response(cur);
        expected_results.insert(expected_results.size(), cur_typed ? cur_exp : pred);
        if (cur.opcode == OP_INSERT) begin
          known_keys.insert(known_keys.size(), cur.lookup_key);
          known_homes.insert(known_homes.size(), cur.home_bucket);
        end
        idx++;
        if (--burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      // present the next command or hold off for the gap
      if (start && busy) begin
        start <= 1'b1;
      end else if (idx < total && gap == 0) begin
        if (idx < DirRows) begin
          cur.opcode      = dir_rows[idx].op;
          cur.lookup_key  = dir_rows[idx].key;
          cur.home_bucket = dir_rows[idx].home;
          cur.new_value   = dir_rows[idx].val;
          cur_typed       = dir_rows[idx].typed;
          cur_exp.status  = dir_rows[idx].st;
          cur_exp.found_value = dir_rows[idx].value;
        end else begin
          cur = random_command();
          cur_typed = 1'b0;
        end
        cmd   <= cur;
        start <= 1'b1;
      end else begin
        if (gap > 0) gap--;
        start <= 1'b0;
      end
    end

    // drain outstanding results, then watch for strays
    while (expected_results.size() > 0) @(posedge clk);
    wait_cycles = 4 * Hops + 64;
    repeat (wait_cycles) @(posedge clk);
    if (expected_results.size() > 0) report_mismatch("results missing at end of run");

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
